FILE: rtl/core/irpd_pkg.sv
// Shared types and constants for the pulse-distance infrared frame sender.
// Used by irpd_csr, irpd_engine and ir_pulse_distance_frame_sender.
package irpd_pkg;

   localparam int FRAME_BYTES  = 12;
   localparam int PAYLOAD_BITS = 96;
   localparam int TOTAL_BITS   = (FRAME_BYTES * 8 > PAYLOAD_BITS) ? PAYLOAD_BITS
                                                                 : FRAME_BYTES * 8;
   localparam int TICK_W       = 16;
   localparam int BITPOS_W     = 7;
   localparam int CSR_INDEX_W  = 3;

   // Item kinds carried on the request tuser bit.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_MARK   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SPACE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_MARK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_SPACE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_SPACE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAILER_SPACE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAILER_MARK  = 3'd6;

   // Reset values of the timing registers, in ticks.
   localparam logic [TICK_W-1:0] RST_HEADER_MARK   = 16'd600;
   localparam logic [TICK_W-1:0] RST_HEADER_SPACE  = 16'd730;
   localparam logic [TICK_W-1:0] RST_BIT_MARK      = 16'd56;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE    = 16'd56;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE     = 16'd168;
   localparam logic [TICK_W-1:0] RST_TRAILER_SPACE = 16'd730;
   localparam logic [TICK_W-1:0] RST_TRAILER_MARK  = 16'd56;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HMARK  = 3'd1,
      PH_HSPACE = 3'd2,
      PH_BMARK  = 3'd3,
      PH_BSPACE = 3'd4,
      PH_TSPACE = 3'd5,
      PH_TMARK  = 3'd6
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] header_mark_ticks;
      logic [TICK_W-1:0] header_space_ticks;
      logic [TICK_W-1:0] bit_mark_ticks;
      logic [TICK_W-1:0] zero_space_ticks;
      logic [TICK_W-1:0] one_space_ticks;
      logic [TICK_W-1:0] trailer_space_ticks;
      logic [TICK_W-1:0] trailer_mark_ticks;
   } cfg_type;

   typedef struct packed {
      logic ir_mark;
      logic busy_res;
      logic frame_done;
   } result_type;

endpackage

FILE: rtl/core/irpd_csr.sv
// Timing register file of the infrared frame sender.
// Depends on irpd_pkg for the register indexes, reset values and cfg_type.
module irpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irpd_pkg::TICK_W-1:0]         csr_data,
   output irpd_pkg::cfg_type                   cfg
);

   irpd_pkg::cfg_type cfg_ff;
   irpd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            irpd_pkg::CSR_HEADER_MARK:   cfg_in.header_mark_ticks   = csr_data;
            irpd_pkg::CSR_HEADER_SPACE:  cfg_in.header_space_ticks  = csr_data;
            irpd_pkg::CSR_BIT_MARK:      cfg_in.bit_mark_ticks      = csr_data;
            irpd_pkg::CSR_ZERO_SPACE:    cfg_in.zero_space_ticks    = csr_data;
            irpd_pkg::CSR_ONE_SPACE:     cfg_in.one_space_ticks     = csr_data;
            irpd_pkg::CSR_TRAILER_SPACE: cfg_in.trailer_space_ticks = csr_data;
            irpd_pkg::CSR_TRAILER_MARK:  cfg_in.trailer_mark_ticks  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_ticks   <= irpd_pkg::RST_HEADER_MARK;
         cfg_ff.header_space_ticks  <= irpd_pkg::RST_HEADER_SPACE;
         cfg_ff.bit_mark_ticks      <= irpd_pkg::RST_BIT_MARK;
         cfg_ff.zero_space_ticks    <= irpd_pkg::RST_ZERO_SPACE;
         cfg_ff.one_space_ticks     <= irpd_pkg::RST_ONE_SPACE;
         cfg_ff.trailer_space_ticks <= irpd_pkg::RST_TRAILER_SPACE;
         cfg_ff.trailer_mark_ticks  <= irpd_pkg::RST_TRAILER_MARK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/irpd_engine.sv
// Frame sequencer: phase state machine, tick counter and payload shifter.
// Depends on irpd_pkg for phase_type, cfg_type, result_type and constants.
module irpd_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 item_kind,
   input  logic [irpd_pkg::PAYLOAD_BITS-1:0]    item_payload,
   input  irpd_pkg::cfg_type                    cfg,
   output irpd_pkg::result_type                 result
);

   irpd_pkg::phase_type                phase_ff, phase_in;
   logic [irpd_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic [irpd_pkg::BITPOS_W-1:0]      bitpos_ff, bitpos_in;
   logic [irpd_pkg::PAYLOAD_BITS-1:0]  payload_ff, payload_in;

   logic                               is_busy;
   logic                               is_mark;
   logic [irpd_pkg::TICK_W-1:0]        len_raw;
   logic [irpd_pkg::TICK_W-1:0]        len_eff;
   logic                               last_tick;
   logic [irpd_pkg::BITPOS_W-1:0]      bitpos_next;

   // The payload shifts left after each bit, so the bit on air is always the MSB.
   always_comb begin
      unique case (phase_ff)
         irpd_pkg::PH_HMARK:  len_raw = cfg.header_mark_ticks;
         irpd_pkg::PH_HSPACE: len_raw = cfg.header_space_ticks;
         irpd_pkg::PH_BMARK:  len_raw = cfg.bit_mark_ticks;
         irpd_pkg::PH_BSPACE: len_raw = payload_ff[irpd_pkg::PAYLOAD_BITS-1]
                                        ? cfg.one_space_ticks : cfg.zero_space_ticks;
         irpd_pkg::PH_TSPACE: len_raw = cfg.trailer_space_ticks;
         irpd_pkg::PH_TMARK:  len_raw = cfg.trailer_mark_ticks;
         default:             len_raw = {{(irpd_pkg::TICK_W-1){1'b0}}, 1'b1};
      endcase
   end

   // A zero length counts as one tick.
   assign len_eff = (len_raw == '0) ? {{(irpd_pkg::TICK_W-1){1'b0}}, 1'b1} : len_raw;
   assign last_tick = ({1'b0, tick_ff} + {{irpd_pkg::TICK_W{1'b0}}, 1'b1})
                      >= {1'b0, len_eff};
   assign bitpos_next = bitpos_ff + {{(irpd_pkg::BITPOS_W-1){1'b0}}, 1'b1};

   always_comb begin
      unique case (phase_ff)
         irpd_pkg::PH_HMARK, irpd_pkg::PH_BMARK, irpd_pkg::PH_TMARK: begin
            is_busy = 1'b1;
            is_mark = 1'b1;
         end
         irpd_pkg::PH_HSPACE, irpd_pkg::PH_BSPACE, irpd_pkg::PH_TSPACE: begin
            is_busy = 1'b1;
            is_mark = 1'b0;
         end
         default: begin
            is_busy = 1'b0;
            is_mark = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bitpos_in  = bitpos_ff;
      payload_in = payload_ff;
      result     = '0;
      if (step) begin
         if (item_kind == irpd_pkg::REQ_START) begin
            result.busy_res = 1'b1;
            if (is_busy) begin
               // A start during a frame is dropped; the current level is reported.
               result.ir_mark = is_mark;
            end else begin
               payload_in = item_payload;
               phase_in   = irpd_pkg::PH_HMARK;
               tick_in    = '0;
               bitpos_in  = '0;
            end
         end else if (is_busy) begin
            result.ir_mark  = is_mark;
            result.busy_res = 1'b1;
            if (last_tick) begin
               tick_in = '0;
               unique case (phase_ff)
                  irpd_pkg::PH_HMARK:  phase_in = irpd_pkg::PH_HSPACE;
                  irpd_pkg::PH_HSPACE: begin
                     phase_in  = irpd_pkg::PH_BMARK;
                     bitpos_in = '0;
                  end
                  irpd_pkg::PH_BMARK:  phase_in = irpd_pkg::PH_BSPACE;
                  irpd_pkg::PH_BSPACE: begin
                     bitpos_in  = bitpos_next;
                     payload_in = {payload_ff[irpd_pkg::PAYLOAD_BITS-2:0], 1'b0};
                     phase_in   = (bitpos_next >= irpd_pkg::BITPOS_W'(irpd_pkg::TOTAL_BITS))
                                  ? irpd_pkg::PH_TSPACE : irpd_pkg::PH_BMARK;
                  end
                  irpd_pkg::PH_TSPACE: phase_in = irpd_pkg::PH_TMARK;
                  default: begin
                     phase_in          = irpd_pkg::PH_IDLE;
                     bitpos_in         = '0;
                     result.frame_done = 1'b1;
                  end
               endcase
            end else begin
               tick_in = tick_ff + {{(irpd_pkg::TICK_W-1){1'b0}}, 1'b1};
            end
         end else begin
            phase_in = irpd_pkg::PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= irpd_pkg::PH_IDLE;
         tick_ff   <= '0;
         bitpos_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bitpos_ff <= bitpos_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

endmodule

FILE: rtl/core/ir_pulse_distance_frame_sender.sv
// Pulse-distance infrared frame sender: one result item per request item.
// Data path: an accepted item waits in the input register, then its result is offered from
// the result register. Throughput: one item per clock while the result side is not stalled;
// the tick counter and phase state machine step at most once per item.
// A stalled result holds back new items only once the input register is also full.
// Reset clears the phase, counters and valid flags and loads the timing defaults.
module ir_pulse_distance_frame_sender (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bytes_first_four [31:0], bytes_last_eight [95:32]
   input  logic [irpd_pkg::PAYLOAD_BITS-1:0]    req_tdata,
   // req_type [0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // ir_mark [0], busy_res [1], zero fill [7:2]
   output logic [7:0]                           rsp_tdata,
   // frame_done
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [irpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [irpd_pkg::TICK_W-1:0]          csr_data
);

   irpd_pkg::cfg_type                  cfg;
   irpd_pkg::result_type               result;

   logic                               in_valid_ff, in_valid_in;
   logic                               in_kind_ff;
   logic [irpd_pkg::PAYLOAD_BITS-1:0]  in_data_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   irpd_pkg::result_type               rsp_ff;
   logic                               advance;
   logic                               req_fire;

   // The held item moves on when the result register is empty or being drained.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The first four bytes [31:0] go to the top of the engine's payload word.
   irpd_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item_kind    (in_kind_ff),
      .item_payload ({in_data_ff[31:0], in_data_ff[irpd_pkg::PAYLOAD_BITS-1:32]}),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ff.busy_res, rsp_ff.ir_mark};
   assign rsp_tlast  = rsp_ff.frame_done;

endmodule

FILE: sim/tb_ir_pulse_distance_frame_sender.sv
// Self-checking testbench for ir_pulse_distance_frame_sender: drives start and tick items,
// predicts the mark/busy/done envelope of every item and compares it in order.
// Depends on irpd_pkg and the ir_pulse_distance_frame_sender RTL.
`timescale 1ns / 1ps

module tb_ir_pulse_distance_frame_sender;
   import irpd_pkg::*;

   localparam int                     STALL_LIMIT = 2000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED  = 3'd7;
   localparam int                     NUM_TIMING  = 7;

   // Tracks the frame the block should be sending and holds the envelope
   // expected for every accepted item, oldest first.
   class envelope_tracker;
      bit [TICK_W-1:0]   tick_len [NUM_TIMING];
      phase_type         phase;
      bit [TICK_W-1:0]   count;
      bit [BITPOS_W-1:0] bitpos;
      bit [31:0]         pay_hi;
      bit [63:0]         pay_lo;
      result_type        envelope_q[$];
      int unsigned       frames_done;
      int unsigned       errors;

      function new();
         tick_len[CSR_HEADER_MARK]   = RST_HEADER_MARK;
         tick_len[CSR_HEADER_SPACE]  = RST_HEADER_SPACE;
         tick_len[CSR_BIT_MARK]      = RST_BIT_MARK;
         tick_len[CSR_ZERO_SPACE]    = RST_ZERO_SPACE;
         tick_len[CSR_ONE_SPACE]     = RST_ONE_SPACE;
         tick_len[CSR_TRAILER_SPACE] = RST_TRAILER_SPACE;
         tick_len[CSR_TRAILER_MARK]  = RST_TRAILER_MARK;
         phase       = PH_IDLE;
         count       = '0;
         bitpos      = '0;
         pay_hi      = '0;
         pay_lo      = '0;
         frames_done = 0;
         errors      = 0;
      endfunction

      function void write_reg(bit [CSR_INDEX_W-1:0] idx, bit [TICK_W-1:0] val);
         if (idx < NUM_TIMING) begin
            tick_len[idx] = val;
         end
      endfunction

      function bit in_frame();
         return phase != PH_IDLE;
      endfunction

      function bit is_mark();
         return phase == PH_HMARK || phase == PH_BMARK || phase == PH_TMARK;
      endfunction

      function bit payload_bit();
         if (bitpos < 32) begin
            return pay_hi[31 - bitpos];
         end
         if (bitpos < PAYLOAD_BITS) begin
            return pay_lo[63 - (bitpos - 32)];
         end
         return 1'b0;
      endfunction

      function int unsigned phase_len();
         bit [TICK_W-1:0] len;
         case (phase)
            PH_HMARK:  len = tick_len[CSR_HEADER_MARK];
            PH_HSPACE: len = tick_len[CSR_HEADER_SPACE];
            PH_BMARK:  len = tick_len[CSR_BIT_MARK];
            PH_BSPACE: len = payload_bit() ? tick_len[CSR_ONE_SPACE] : tick_len[CSR_ZERO_SPACE];
            PH_TSPACE: len = tick_len[CSR_TRAILER_SPACE];
            PH_TMARK:  len = tick_len[CSR_TRAILER_MARK];
            default:   len = TICK_W'(1);
         endcase
         // A programmed length of zero still lasts one tick.
         return (len == '0) ? 32'd1 : 32'(len);
      endfunction

      function void advance_on_request(bit kind, bit [PAYLOAD_BITS-1:0] data);
         result_type r;
         r = '0;
         if (kind == REQ_START) begin
            r.busy_res = 1'b1;
            if (in_frame()) begin
               // A start during a frame is dropped; the current level is reported.
               r.ir_mark = is_mark();
            end else begin
               pay_hi = data[31:0];
               pay_lo = data[95:32];
               phase  = PH_HMARK;
               count  = '0;
               bitpos = '0;
            end
         end else if (in_frame()) begin
            r.ir_mark  = is_mark();
            r.busy_res = 1'b1;
            if (int'(count) + 1 >= phase_len()) begin
               count = '0;
               case (phase)
                  PH_HMARK:  phase = PH_HSPACE;
                  PH_HSPACE: begin
                     phase  = PH_BMARK;
                     bitpos = '0;
                  end
                  PH_BMARK:  phase = PH_BSPACE;
                  PH_BSPACE: begin
                     bitpos = bitpos + 1'b1;
                     phase  = (bitpos >= TOTAL_BITS) ? PH_TSPACE : PH_BMARK;
                  end
                  PH_TSPACE: phase = PH_TMARK;
                  default: begin
                     phase        = PH_IDLE;
                     bitpos       = '0;
                     r.frame_done = 1'b1;
                     frames_done++;
                  end
               endcase
            end else begin
               count = count + 1'b1;
            end
         end else begin
            phase = PH_IDLE;
         end
         envelope_q.push_back(r);
      endfunction

      function void compare_envelope(result_type got);
         result_type exp;
         if (envelope_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %b", $time, got);
            errors++;
            return;
         end
         exp = envelope_q.pop_front();
         if (exp.ir_mark != got.ir_mark) begin
            $display("%0t ir_mark mismatch: expected %0b, actual %0b",
                     $time, exp.ir_mark, got.ir_mark);
            errors++;
         end
         if (exp.busy_res != got.busy_res) begin
            $display("%0t busy_res mismatch: expected %0b, actual %0b",
                     $time, exp.busy_res, got.busy_res);
            errors++;
         end
         if (exp.frame_done != got.frame_done) begin
            $display("%0t frame_done mismatch: expected %0b, actual %0b",
                     $time, exp.frame_done, got.frame_done);
            errors++;
         end
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PAYLOAD_BITS-1:0] req_tdata  = '0;
   logic                    req_tuser  = REQ_TICK;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [7:0]              rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [TICK_W-1:0]       csr_data   = '0;

   envelope_tracker tracker = new();
   result_type      got_rsp;
   int unsigned     send_idle_pct = 8;
   int unsigned     recv_idle_pct = 50;
   int unsigned     stall_cycles  = 0;

   ir_pulse_distance_frame_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.ir_mark    = rsp_tdata[0];
         got_rsp.busy_res   = rsp_tdata[1];
         got_rsp.frame_done = rsp_tlast;
         tracker.compare_envelope(got_rsp);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
         $display("tb_ir_pulse_distance_frame_sender: errors");
         $finish;
      end
   end

   function automatic bit [PAYLOAD_BITS-1:0] random_payload();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom, $urandom};
      endcase
   endfunction

   function automatic bit [TICK_W-1:0] rand_len(int unsigned hi);
      return TICK_W'($urandom_range(hi, 1));
   endfunction

   task automatic send_item(bit kind, bit [PAYLOAD_BITS-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      tracker.advance_on_request(kind, data);
   endtask

   task automatic csr_write(bit [CSR_INDEX_W-1:0] idx, bit [TICK_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   task automatic load_timing(bit [TICK_W-1:0] hm, bit [TICK_W-1:0] hs, bit [TICK_W-1:0] bm,
                              bit [TICK_W-1:0] zs, bit [TICK_W-1:0] os, bit [TICK_W-1:0] ts,
                              bit [TICK_W-1:0] tm);
      csr_write(CSR_HEADER_MARK, hm);
      csr_write(CSR_HEADER_SPACE, hs);
      csr_write(CSR_BIT_MARK, bm);
      csr_write(CSR_ZERO_SPACE, zs);
      csr_write(CSR_ONE_SPACE, os);
      csr_write(CSR_TRAILER_SPACE, ts);
      csr_write(CSR_TRAILER_MARK, tm);
      csr_valid <= 1'b0;
   endtask

   // Every item returns a result, so an empty queue plus the two-stage latency
   // means the block is quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.envelope_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Mostly ticks; starts come often while no frame is running and rarely
   // during one, where they must be dropped.
   task automatic run_stream(int unsigned n_items, int unsigned min_frames,
                             int unsigned start_pct);
      int unsigned sent;
      int unsigned frames_at_entry;
      bit          kind;
      sent            = 0;
      frames_at_entry = tracker.frames_done;
      while (sent < n_items || tracker.frames_done - frames_at_entry < min_frames) begin
         if (!tracker.in_frame()) begin
            kind = ($urandom_range(99) < start_pct) ? REQ_START : REQ_TICK;
         end else begin
            kind = ($urandom_range(199) == 0) ? REQ_START : REQ_TICK;
         end
         send_item(kind, random_payload());
         sent++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: ticks while idle, a start, dropped starts, ticks in the header.
      send_item(REQ_TICK, '0);
      send_item(REQ_TICK, '1);
      send_item(REQ_START, {64'h0, 32'hFFFF_FFFF});
      send_item(REQ_START, '0);
      repeat (15) send_item(REQ_TICK, random_payload());
      send_item(REQ_START, '1);
      repeat (4) send_item(REQ_TICK, '0);

      // Shortest legal timing; shrinks the running header in mid frame.
      drain();
      load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_stream(200, 2, 30);

      // Zero lengths behave as one tick; the unused index must change nothing.
      drain();
      csr_write(CSR_UNUSED, TICK_W'($urandom));
      load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_stream(150, 1, 30);

      send_idle_pct = 50;
      recv_idle_pct = 8;
      drain();
      load_timing(rand_len(4), rand_len(4), rand_len(4), rand_len(4), rand_len(4),
                  rand_len(4), rand_len(4));
      run_stream(100, 0, 30);

      drain();
      load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_stream(60, 0, 100);

      drain();
      load_timing(rand_len(8), rand_len(8), rand_len(8), rand_len(8), rand_len(8),
                  rand_len(8), rand_len(8));
      run_stream(100, 0, 30);

      // Neither side idles from here on.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain();
      load_timing(rand_len(3), rand_len(3), rand_len(3), rand_len(3), rand_len(3),
                  rand_len(3), rand_len(3));
      run_stream(100, 0, 30);

      drain();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.envelope_q.size() == 0) begin
         $display("tb_ir_pulse_distance_frame_sender: clean");
      end else begin
         $display("tb_ir_pulse_distance_frame_sender: errors");
      end
      $finish;
   end

endmodule

FILE: ir_pulse_distance_frame_sender.f
rtl/core/irpd_pkg.sv
rtl/core/irpd_csr.sv
rtl/core/irpd_engine.sv
rtl/core/ir_pulse_distance_frame_sender.sv
sim/tb_ir_pulse_distance_frame_sender.sv
